FILE: design/i2cbm_pkg.sv
`default_nettype none
package i2cbm_pkg;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_WAIT    = 3'd4,
    OP_RD_ACK  = 3'd5,
    OP_RD_NACK = 3'd6,
    OP_RD_BARE = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_WR_LO   = 4'd5,
    PH_WR_HI   = 4'd6,
    PH_WR_TAIL = 4'd7,
    PH_RD_LO   = 4'd8,
    PH_RD_HI   = 4'd9,
    PH_AK_LO   = 4'd10,
    PH_AK_HI   = 4'd11,
    PH_WA_SET  = 4'd12,
    PH_WA_HI   = 4'd13,
    PH_WA_POLL = 4'd14
  } phase_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PHASE_TICKS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT  = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RST  = 16'd4;
  localparam logic [15:0] SETTLE_TICKS_RST = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] settle_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

  // Per-tick control from the sequencer to the pin/data path
  typedef struct packed {
    phase_t phase;
    op_t    cmd;
    logic   enter;
    logic   load_tx;
    logic   clr_shift;
    logic   fail_clr;
    logic   fail_set;
    logic   sample;
    logic   rx_load;
    logic   scl_clr;
    logic   done;
  } ctl_t;

endpackage
`default_nettype wire

FILE: design/i2cbm_cfg.sv
`default_nettype none
module i2cbm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [i2cbm_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [i2cbm_pkg::CfgDataW-1:0]  cfg_data,
  output i2cbm_pkg::cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks  <= i2cbm_pkg::PHASE_TICKS_RST;
      cfg.settle_ticks <= i2cbm_pkg::SETTLE_TICKS_RST;
      cfg.ack_timeout  <= i2cbm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_valid) begin
      // indexes past the register list are dropped
      unique case (cfg_index)
        i2cbm_pkg::CFG_PHASE_TICKS:  cfg.phase_ticks  <= cfg_data;
        i2cbm_pkg::CFG_SETTLE_TICKS: cfg.settle_ticks <= cfg_data;
        i2cbm_pkg::CFG_ACK_TIMEOUT:  cfg.ack_timeout  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/i2cbm_ctrl.sv
`default_nettype none
module i2cbm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [2:0]      opcode,
  input  wire logic            sda_in,
  input  wire i2cbm_pkg::cfg_t cfg,
  output i2cbm_pkg::ctl_t      ctl
);

  i2cbm_pkg::phase_t phase, phase_next;
  i2cbm_pkg::op_t    command, command_next;
  logic [15:0] tick_count, tick_next;
  logic [3:0]  bit_count, bit_next;
  logic [7:0]  poll_count, poll_next;

  i2cbm_pkg::op_t op;
  logic [16:0] tick_inc;
  logic [15:0] dur;
  logic [15:0] dur_eff;
  logic        tick_done;
  logic [3:0]  bit_inc;
  logic        more_bits;
  logic [8:0]  poll_inc;
  logic        poll_fail;

  assign op        = i2cbm_pkg::op_t'(opcode);
  assign tick_inc  = {1'b0, tick_count} + 17'd1;
  assign dur       = (phase == i2cbm_pkg::PH_WA_SET || phase == i2cbm_pkg::PH_WA_HI) ?
                     cfg.settle_ticks : cfg.phase_ticks;
  assign dur_eff   = (dur == 16'd0) ? 16'd1 : dur;
  assign tick_done = tick_inc >= {1'b0, dur_eff};
  assign bit_inc   = bit_count + 4'd1;
  assign more_bits = bit_inc < i2cbm_pkg::BITS_PER_BYTE;
  assign poll_inc  = {1'b0, poll_count} + 9'd1;
  assign poll_fail = poll_inc > {1'b0, cfg.ack_timeout};

  // next state
  always_comb begin
    phase_next   = phase;
    command_next = command;
    tick_next    = tick_count;
    bit_next     = bit_count;
    poll_next    = poll_count;
    unique case (phase)
      i2cbm_pkg::PH_IDLE: begin
        if (op != i2cbm_pkg::OP_NONE) begin
          command_next = op;
          bit_next     = 4'd0;
          tick_next    = 16'd0;
          unique case (op)
            i2cbm_pkg::OP_START: phase_next = i2cbm_pkg::PH_ST_A;
            i2cbm_pkg::OP_STOP:  phase_next = i2cbm_pkg::PH_SP_A;
            i2cbm_pkg::OP_WRITE: phase_next = i2cbm_pkg::PH_WR_LO;
            i2cbm_pkg::OP_WAIT:  phase_next = i2cbm_pkg::PH_WA_SET;
            default:             phase_next = i2cbm_pkg::PH_RD_LO;
          endcase
        end
      end
      i2cbm_pkg::PH_WA_POLL: begin
        if (!sda_in) begin
          phase_next = i2cbm_pkg::PH_IDLE;
        end else if (poll_fail) begin
          phase_next = i2cbm_pkg::PH_SP_A;
          tick_next  = 16'd0;
        end else begin
          poll_next = poll_inc[7:0];
        end
      end
      default: begin
        tick_next = tick_inc[15:0];
        if (tick_done) begin
          unique case (phase)
            i2cbm_pkg::PH_ST_A:  phase_next = i2cbm_pkg::PH_ST_B;
            i2cbm_pkg::PH_SP_A:  phase_next = i2cbm_pkg::PH_SP_B;
            i2cbm_pkg::PH_WR_LO: phase_next = i2cbm_pkg::PH_WR_HI;
            i2cbm_pkg::PH_WR_HI: phase_next = i2cbm_pkg::PH_WR_TAIL;
            i2cbm_pkg::PH_WR_TAIL: begin
              bit_next   = bit_inc;
              phase_next = more_bits ? i2cbm_pkg::PH_WR_LO : i2cbm_pkg::PH_IDLE;
            end
            i2cbm_pkg::PH_RD_LO: phase_next = i2cbm_pkg::PH_RD_HI;
            i2cbm_pkg::PH_RD_HI: begin
              bit_next = bit_inc;
              if (more_bits)
                phase_next = i2cbm_pkg::PH_RD_LO;
              else if (command == i2cbm_pkg::OP_RD_BARE)
                phase_next = i2cbm_pkg::PH_IDLE;
              else
                phase_next = i2cbm_pkg::PH_AK_LO;
            end
            i2cbm_pkg::PH_AK_LO:  phase_next = i2cbm_pkg::PH_AK_HI;
            i2cbm_pkg::PH_WA_SET: phase_next = i2cbm_pkg::PH_WA_HI;
            i2cbm_pkg::PH_WA_HI: begin
              phase_next = i2cbm_pkg::PH_WA_POLL;
              poll_next  = 8'd0;
            end
            default: phase_next = i2cbm_pkg::PH_IDLE;
          endcase
          // every move into a busy phase restarts the tick count
          if (phase_next != i2cbm_pkg::PH_IDLE) tick_next = 16'd0;
        end
      end
    endcase
  end

  // control outputs
  always_comb begin
    ctl       = '0;
    ctl.phase = phase_next;
    ctl.cmd   = command_next;
    unique case (phase)
      i2cbm_pkg::PH_IDLE: begin
        if (op != i2cbm_pkg::OP_NONE) begin
          ctl.enter     = 1'b1;
          ctl.load_tx   = (op == i2cbm_pkg::OP_WRITE);
          ctl.clr_shift = (op == i2cbm_pkg::OP_RD_ACK) || (op == i2cbm_pkg::OP_RD_NACK) ||
                          (op == i2cbm_pkg::OP_RD_BARE);
          ctl.fail_clr  = (op == i2cbm_pkg::OP_WAIT);
        end
      end
      i2cbm_pkg::PH_WA_POLL: begin
        if (!sda_in) begin
          ctl.scl_clr = 1'b1;
          ctl.done    = 1'b1;
        end else if (poll_fail) begin
          ctl.fail_set = 1'b1;
          ctl.enter    = 1'b1;
        end
      end
      default: begin
        if (tick_done) begin
          unique case (phase)
            i2cbm_pkg::PH_ST_B, i2cbm_pkg::PH_AK_HI: begin
              ctl.scl_clr = 1'b1;
              ctl.done    = 1'b1;
            end
            i2cbm_pkg::PH_SP_B: ctl.done = 1'b1;
            i2cbm_pkg::PH_WR_TAIL: begin
              ctl.enter = more_bits;
              ctl.done  = !more_bits;
            end
            i2cbm_pkg::PH_RD_HI: begin
              ctl.sample = (command != i2cbm_pkg::OP_RD_BARE);
              if (more_bits) begin
                ctl.enter = 1'b1;
              end else begin
                ctl.rx_load = 1'b1;
                ctl.done    = (command == i2cbm_pkg::OP_RD_BARE);
                ctl.enter   = (command != i2cbm_pkg::OP_RD_BARE);
              end
            end
            default: ctl.enter = 1'b1;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cbm_pkg::PH_IDLE;
      command    <= i2cbm_pkg::OP_NONE;
      tick_count <= 16'd0;
      bit_count  <= 4'd0;
      poll_count <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      command    <= command_next;
      tick_count <= tick_next;
      bit_count  <= bit_next;
      poll_count <= poll_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/i2cbm_dp.sv
`default_nettype none
module i2cbm_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      tx_byte,
  input  wire logic            sda_in,
  input  wire i2cbm_pkg::ctl_t ctl,
  output logic                 scl_next,
  output logic                 sda_next,
  output logic                 drv_next,
  output logic [7:0]           rx_next,
  output logic                 fail_next
);

  logic       scl, sda, drv, fail_flag;
  logic       scl_q, sda_q, drv_q, fail_q;
  logic [7:0] shift_reg, shift_next, shift_a, rx_hold;

  always_comb begin
    if (ctl.load_tx)        shift_a = tx_byte;
    else if (ctl.clr_shift) shift_a = 8'd0;
    else if (ctl.sample)    shift_a = {shift_reg[6:0], sda_in};
    else                    shift_a = shift_reg;

    scl        = scl_q;
    sda        = sda_q;
    drv        = drv_q;
    shift_next = shift_a;
    rx_next    = ctl.rx_load ? shift_a : rx_hold;
    fail_flag  = fail_q;
    if (ctl.fail_clr) fail_flag = 1'b0;
    if (ctl.fail_set) fail_flag = 1'b1;
    if (ctl.scl_clr)  scl = 1'b0;

    // pin setup on the first tick of a phase
    if (ctl.enter) begin
      unique case (ctl.phase)
        i2cbm_pkg::PH_ST_A: begin
          scl = 1'b1; sda = 1'b1; drv = 1'b1;
        end
        i2cbm_pkg::PH_ST_B: sda = 1'b0;
        i2cbm_pkg::PH_SP_A: begin
          drv = 1'b1; scl = 1'b0; sda = 1'b0;
        end
        i2cbm_pkg::PH_SP_B: begin
          scl = 1'b1; sda = 1'b1;
        end
        i2cbm_pkg::PH_WR_LO: begin
          drv        = 1'b1;
          scl        = 1'b0;
          sda        = shift_a[7];
          shift_next = {shift_a[6:0], 1'b0};
        end
        i2cbm_pkg::PH_WR_HI, i2cbm_pkg::PH_AK_HI, i2cbm_pkg::PH_WA_HI: scl = 1'b1;
        i2cbm_pkg::PH_WR_TAIL: scl = 1'b0;
        i2cbm_pkg::PH_RD_LO: begin
          drv = 1'b0; scl = 1'b0; sda = 1'b1;
        end
        i2cbm_pkg::PH_RD_HI: begin
          scl = 1'b1;
          // bare read samples at the rising edge of SCL
          if (ctl.cmd == i2cbm_pkg::OP_RD_BARE) shift_next = {shift_a[6:0], sda_in};
        end
        i2cbm_pkg::PH_AK_LO: begin
          scl = 1'b0;
          drv = 1'b1;
          sda = (ctl.cmd == i2cbm_pkg::OP_RD_NACK);
        end
        i2cbm_pkg::PH_WA_SET: begin
          drv = 1'b0; sda = 1'b1;
        end
        default: ;
      endcase
    end
    scl_next  = scl;
    sda_next  = sda;
    drv_next  = drv;
    fail_next = fail_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      drv_q     <= 1'b1;
      fail_q    <= 1'b0;
      shift_reg <= 8'd0;
      rx_hold   <= 8'd0;
    end else if (step) begin
      scl_q     <= scl_next;
      sda_q     <= sda_next;
      drv_q     <= drv_next;
      fail_q    <= fail_next;
      shift_reg <= shift_next;
      rx_hold   <= rx_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/i2c_bit_level_master.sv
// I2C bit-level bus master, one bus tick per transaction.
// Input channel (in_valid/in_ready): opcode, tx_byte and the sampled SDA
// level for one tick. Opcodes are taken only while no command is busy;
// others are ignored. Each accepted tick yields exactly one result on the
// output channel (out_valid/out_ready): SCL/SDA levels, SDA drive enable,
// busy, a one-tick done pulse, the last received byte and the ack failure.
// The tick is evaluated by the sequencer and data path in the cycle it is
// accepted and the result appears in the output register on the next cycle.
// One tick per cycle is taken while in_ready is high; in_ready stays high
// while the output register is empty or being taken in the same cycle.
// When the receiver stalls, the result holds and in_ready drops until it
// is taken; no tick is lost and the bus state does not advance.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 phase_ticks, 1 settle_ticks, 2 ack_timeout; other indexes drop.
// Reset: idle, SCL high, SDA high and driven, counters and flags cleared,
// phase_ticks 4, settle_ticks 2, ack_timeout 250, output register empty.
`default_nettype none
module i2c_bit_level_master (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      opcode,
  input  wire logic [7:0]                      tx_byte,
  input  wire logic                            sda_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 scl_level,
  output logic                                 sda_level,
  output logic                                 sda_drive,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [7:0]                           rx_byte,
  output logic                                 ack_fail,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [i2cbm_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [i2cbm_pkg::CfgDataW-1:0]  cfg_data
);

  i2cbm_pkg::cfg_t cfg;
  i2cbm_pkg::ctl_t ctl;
  logic       step;
  logic       scl_next, sda_next, drv_next, fail_next;
  logic [7:0] rx_next;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  i2cbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2cbm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .opcode (opcode),
    .sda_in (sda_in),
    .cfg    (cfg),
    .ctl    (ctl)
  );

  i2cbm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .ctl       (ctl),
    .scl_next  (scl_next),
    .sda_next  (sda_next),
    .drv_next  (drv_next),
    .rx_next   (rx_next),
    .fail_next (fail_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register; hold while stalled
  always_ff @(posedge clk) begin
    if (step) begin
      scl_level <= scl_next;
      sda_level <= sda_next;
      sda_drive <= drv_next;
      busy_res  <= (ctl.phase != i2cbm_pkg::PH_IDLE);
      done_res  <= ctl.done;
      rx_byte   <= rx_next;
      ack_fail  <= fail_next;
    end
  end

endmodule
`default_nettype wire

FILE: sim/i2c_bus_monitor.sv
`default_nettype none
module i2c_bus_monitor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [2:0]                     opcode,
  input  wire logic [7:0]                     tx_byte,
  input  wire logic                           sda_in,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           scl_level,
  input  wire logic                           sda_level,
  input  wire logic                           sda_drive,
  input  wire logic                           busy_res,
  input  wire logic                           done_res,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic                           ack_fail,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [i2cbm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [i2cbm_pkg::CfgDataW-1:0] cfg_data,
  output int                                  mismatch_count,
  output int                                  outstanding,
  output logic                                bus_busy
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } bus_pins_t;

  logic [15:0] phase_ticks_q;
  logic [15:0] settle_ticks_q;
  logic [7:0]  ack_timeout_q;

  i2cbm_pkg::phase_t ph;
  i2cbm_pkg::op_t    cmd;
  logic [15:0] ticks;
  logic [3:0]  bits;
  logic [7:0]  shifter;
  logic [7:0]  polls;
  logic [7:0]  rx_held;
  logic        scl_q;
  logic        sda_q;
  logic        drv_q;
  logic        fail_q;

  bus_pins_t   expected_pins[$];
  int          mismatches = 0;

  function automatic logic [15:0] segment_ticks();
    logic [15:0] d;
    d = (ph == i2cbm_pkg::PH_WA_SET || ph == i2cbm_pkg::PH_WA_HI) ?
        settle_ticks_q : phase_ticks_q;
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  // Set the pins a segment starts with and restart its tick count.
  task automatic enter_segment(input i2cbm_pkg::phase_t nxt, input logic sda);
    ph = nxt;
    ticks = 16'd0;
    case (nxt)
      i2cbm_pkg::PH_ST_A: begin
        drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
      end
      i2cbm_pkg::PH_ST_B: sda_q = 1'b0;
      i2cbm_pkg::PH_SP_A: begin
        drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
      end
      i2cbm_pkg::PH_SP_B: begin
        scl_q = 1'b1; sda_q = 1'b1;
      end
      i2cbm_pkg::PH_WR_LO: begin
        drv_q = 1'b1; scl_q = 1'b0;
        sda_q = shifter[7];
        shifter = {shifter[6:0], 1'b0};
      end
      i2cbm_pkg::PH_WR_HI: scl_q = 1'b1;
      i2cbm_pkg::PH_WR_TAIL: scl_q = 1'b0;
      i2cbm_pkg::PH_RD_LO: begin
        drv_q = 1'b0; scl_q = 1'b0; sda_q = 1'b1;
      end
      i2cbm_pkg::PH_RD_HI: begin
        scl_q = 1'b1;
        // bare read samples at the start of the high half
        if (cmd == i2cbm_pkg::OP_RD_BARE) shifter = {shifter[6:0], sda};
      end
      i2cbm_pkg::PH_AK_LO: begin
        scl_q = 1'b0; drv_q = 1'b1;
        sda_q = (cmd == i2cbm_pkg::OP_RD_NACK);
      end
      i2cbm_pkg::PH_AK_HI: scl_q = 1'b1;
      i2cbm_pkg::PH_WA_SET: begin
        drv_q = 1'b0; sda_q = 1'b1;
      end
      i2cbm_pkg::PH_WA_HI: scl_q = 1'b1;
      i2cbm_pkg::PH_WA_POLL: polls = 8'd0;
      default: ph = i2cbm_pkg::PH_IDLE;
    endcase
  endtask

  task automatic advance_bus_tick(input logic [2:0] op, input logic [7:0] txb,
                                  input logic sda, output bus_pins_t pins);
    logic done;
    done = 1'b0;
    if (ph == i2cbm_pkg::PH_IDLE) begin
      if (op != i2cbm_pkg::OP_NONE) begin
        cmd = i2cbm_pkg::op_t'(op);
        bits = 4'd0;
        case (i2cbm_pkg::op_t'(op))
          i2cbm_pkg::OP_START: enter_segment(i2cbm_pkg::PH_ST_A, sda);
          i2cbm_pkg::OP_STOP: enter_segment(i2cbm_pkg::PH_SP_A, sda);
          i2cbm_pkg::OP_WRITE: begin
            shifter = txb;
            enter_segment(i2cbm_pkg::PH_WR_LO, sda);
          end
          i2cbm_pkg::OP_WAIT: begin
            fail_q = 1'b0;
            enter_segment(i2cbm_pkg::PH_WA_SET, sda);
          end
          default: begin
            shifter = 8'd0;
            enter_segment(i2cbm_pkg::PH_RD_LO, sda);
          end
        endcase
      end
    end else if (ph == i2cbm_pkg::PH_WA_POLL) begin
      if (!sda) begin
        scl_q = 1'b0;
        ph = i2cbm_pkg::PH_IDLE;
        done = 1'b1;
      end else if ({1'b0, polls} + 9'd1 > {1'b0, ack_timeout_q}) begin
        // give up: flag it and release the bus with a stop
        fail_q = 1'b1;
        enter_segment(i2cbm_pkg::PH_SP_A, sda);
      end else begin
        polls = polls + 8'd1;
      end
    end else begin
      ticks = ticks + 16'd1;
      if (ticks >= segment_ticks()) begin
        case (ph)
          i2cbm_pkg::PH_ST_A: enter_segment(i2cbm_pkg::PH_ST_B, sda);
          i2cbm_pkg::PH_ST_B: begin
            scl_q = 1'b0; ph = i2cbm_pkg::PH_IDLE; done = 1'b1;
          end
          i2cbm_pkg::PH_SP_A: enter_segment(i2cbm_pkg::PH_SP_B, sda);
          i2cbm_pkg::PH_SP_B: begin
            ph = i2cbm_pkg::PH_IDLE; done = 1'b1;
          end
          i2cbm_pkg::PH_WR_LO: enter_segment(i2cbm_pkg::PH_WR_HI, sda);
          i2cbm_pkg::PH_WR_HI: enter_segment(i2cbm_pkg::PH_WR_TAIL, sda);
          i2cbm_pkg::PH_WR_TAIL: begin
            bits = bits + 4'd1;
            if (bits < i2cbm_pkg::BITS_PER_BYTE) enter_segment(i2cbm_pkg::PH_WR_LO, sda);
            else begin
              ph = i2cbm_pkg::PH_IDLE; done = 1'b1;
            end
          end
          i2cbm_pkg::PH_RD_LO: enter_segment(i2cbm_pkg::PH_RD_HI, sda);
          i2cbm_pkg::PH_RD_HI: begin
            if (cmd != i2cbm_pkg::OP_RD_BARE) shifter = {shifter[6:0], sda};
            bits = bits + 4'd1;
            if (bits < i2cbm_pkg::BITS_PER_BYTE) enter_segment(i2cbm_pkg::PH_RD_LO, sda);
            else begin
              rx_held = shifter;
              if (cmd == i2cbm_pkg::OP_RD_BARE) begin
                ph = i2cbm_pkg::PH_IDLE; done = 1'b1;
              end else begin
                enter_segment(i2cbm_pkg::PH_AK_LO, sda);
              end
            end
          end
          i2cbm_pkg::PH_AK_LO: enter_segment(i2cbm_pkg::PH_AK_HI, sda);
          i2cbm_pkg::PH_AK_HI: begin
            scl_q = 1'b0; ph = i2cbm_pkg::PH_IDLE; done = 1'b1;
          end
          i2cbm_pkg::PH_WA_SET: enter_segment(i2cbm_pkg::PH_WA_HI, sda);
          i2cbm_pkg::PH_WA_HI: enter_segment(i2cbm_pkg::PH_WA_POLL, sda);
          default: ph = i2cbm_pkg::PH_IDLE;
        endcase
      end
    end
    pins = '{scl: scl_q, sda: sda_q, drv: drv_q, busy: (ph != i2cbm_pkg::PH_IDLE),
             done: done, rx: rx_held, fail: fail_q};
  endtask

  always @(posedge clk) begin : watch
    bus_pins_t want;
    bus_pins_t got;
    if (rst) begin
      phase_ticks_q = i2cbm_pkg::PHASE_TICKS_RST;
      settle_ticks_q = i2cbm_pkg::SETTLE_TICKS_RST;
      ack_timeout_q = i2cbm_pkg::ACK_TIMEOUT_RST;
      ph = i2cbm_pkg::PH_IDLE;
      cmd = i2cbm_pkg::OP_NONE;
      ticks = 16'd0;
      bits = 4'd0;
      shifter = 8'd0;
      polls = 8'd0;
      rx_held = 8'd0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      drv_q = 1'b1;
      fail_q = 1'b0;
      expected_pins.delete();
    end else begin
      // retire results first so a result never matches an item of this same edge
      if (out_valid && out_ready) begin
        got = '{scl: scl_level, sda: sda_level, drv: sda_drive, busy: busy_res,
                done: done_res, rx: rx_byte, fail: ack_fail};
        if (expected_pins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result with no transaction pending: ",
                      "scl=%b sda=%b drv=%b busy=%b done=%b rx=%h fail=%b"},
                     $realtime, got.scl, got.sda, got.drv, got.busy, got.done, got.rx,
                     got.fail);
        end else begin
          want = expected_pins.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.drv !== want.drv ||
              got.busy !== want.busy || got.done !== want.done ||
              got.rx !== want.rx || got.fail !== want.fail) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch  scl sda drv busy done rx fail", $realtime);
              $display("  expected   %b   %b   %b   %b    %b    %h  %b", want.scl, want.sda,
                       want.drv, want.busy, want.done, want.rx, want.fail);
              $display("  actual     %b   %b   %b   %b    %b    %h  %b", got.scl, got.sda,
                       got.drv, got.busy, got.done, got.rx, got.fail);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          i2cbm_pkg::CFG_PHASE_TICKS: phase_ticks_q = cfg_data;
          i2cbm_pkg::CFG_SETTLE_TICKS: settle_ticks_q = cfg_data;
          i2cbm_pkg::CFG_ACK_TIMEOUT: ack_timeout_q = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_bus_tick(opcode, tx_byte, sda_in, want);
        expected_pins.push_back(want);
      end
    end
    mismatch_count <= mismatches;
    outstanding <= expected_pins.size();
    bus_busy <= (ph != i2cbm_pkg::PH_IDLE);
  end

endmodule
`default_nettype wire

FILE: sim/i2c_bit_level_master_test.sv
`default_nettype none
module i2c_bit_level_master_test;

  localparam int unsigned CycleLimit = 50_000;
  localparam logic [i2cbm_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    SDA_NOISE,
    SDA_HIGH,
    SDA_LOW
  } sda_plan_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic [2:0]                     opcode = i2cbm_pkg::OP_NONE;
  logic [7:0]                     tx_byte = 8'd0;
  logic                           sda_in = 1'b1;
  logic                           out_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [i2cbm_pkg::CfgIdxW-1:0]  cfg_index = i2cbm_pkg::CFG_PHASE_TICKS;
  logic [i2cbm_pkg::CfgDataW-1:0] cfg_data = '0;

  logic                in_ready;
  logic                out_valid;
  logic                scl_level;
  logic                sda_level;
  logic                sda_drive;
  logic                busy_res;
  logic                done_res;
  logic [7:0]          rx_byte;
  logic                ack_fail;
  logic                cfg_ready;

  int                  mismatch_count;
  int                  outstanding;
  logic                bus_busy;

  logic                calm = 1'b0;
  sda_plan_t           sda_plan = SDA_NOISE;
  int unsigned         cycles = 0;

  i2c_bit_level_master uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .tx_byte   (tx_byte),
    .sda_in    (sda_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .sda_drive (sda_drive),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .ack_fail  (ack_fail),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2c_bus_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .tx_byte        (tx_byte),
    .sda_in         (sda_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scl_level      (scl_level),
    .sda_level      (sda_level),
    .sda_drive      (sda_drive),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .rx_byte        (rx_byte),
    .ack_fail       (ack_fail),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .bus_busy       (bus_busy)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= calm || ($urandom_range(99) >= 23);
    if (cycles >= CycleLimit) begin
      $display("** i2c_bit_level_master: FAILED **");
      $finish;
    end
  end

  function automatic logic next_sda();
    case (sda_plan)
      SDA_HIGH: return 1'b1;
      SDA_LOW: return 1'b0;
      default: return 1'($urandom_range(1));
    endcase
  endfunction

  function automatic sda_plan_t pick_plan();
    int r;
    r = $urandom_range(3);
    return (r == 0) ? SDA_HIGH : (r == 1) ? SDA_LOW : SDA_NOISE;
  endfunction

  function automatic logic [2:0] pick_op();
    logic [2:0] op;
    op = 3'($urandom_range(1, 7));
    return ($urandom_range(99) < 10) ? i2cbm_pkg::OP_NONE : op;
  endfunction

  // One tick per transaction; valid stays up between back-to-back ticks.
  task automatic send_tick(input logic [2:0] op, input logic [7:0] b);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    tx_byte <= b;
    sda_in <= next_sda();
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic flush();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Tick the sequencer until the current command has run out.
  task automatic settle_bus();
    do begin
      while (bus_busy) send_tick(i2cbm_pkg::OP_NONE, 8'($urandom));
      flush();
    end while (bus_busy);
  endtask

  task automatic run_command(input i2cbm_pkg::op_t op, input logic [7:0] b,
                             input sda_plan_t plan);
    sda_plan = plan;
    send_tick(op, b);
    settle_bus();
  endtask

  task automatic write_reg(input logic [i2cbm_pkg::CfgIdxW-1:0] idx,
                           input logic [i2cbm_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_ticks(input int count);
    for (int k = 0; k < count; k++) begin
      if (!bus_busy) sda_plan = pick_plan();
      send_tick(pick_op(), 8'($urandom));
    end
    settle_bus();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset timing
    run_command(i2cbm_pkg::OP_NONE, 8'h00, SDA_NOISE);
    run_command(i2cbm_pkg::OP_START, 8'($urandom), SDA_NOISE);
    run_command(i2cbm_pkg::OP_WRITE, 8'hA5, SDA_NOISE);
    run_command(i2cbm_pkg::OP_WAIT, 8'($urandom), SDA_LOW);
    run_command(i2cbm_pkg::OP_WAIT, 8'($urandom), SDA_HIGH);
    run_command(i2cbm_pkg::OP_STOP, 8'($urandom), SDA_NOISE);

    // shortest segments, fail on the second high poll
    write_reg(i2cbm_pkg::CFG_PHASE_TICKS, 16'd1);
    write_reg(i2cbm_pkg::CFG_SETTLE_TICKS, 16'd1);
    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, 16'd1);
    write_reg(CFG_UNUSED, 16'($urandom));
    run_command(i2cbm_pkg::OP_WRITE, 8'hFF, SDA_NOISE);
    run_command(i2cbm_pkg::OP_WAIT, 8'($urandom), SDA_HIGH);
    run_command(i2cbm_pkg::OP_WAIT, 8'($urandom), SDA_LOW);
    run_command(i2cbm_pkg::OP_RD_BARE, 8'($urandom), SDA_HIGH);
    run_command(i2cbm_pkg::OP_RD_ACK, 8'($urandom), SDA_LOW);
    run_command(i2cbm_pkg::OP_RD_NACK, 8'($urandom), SDA_NOISE);

    calm <= 1'b1;
    write_reg(i2cbm_pkg::CFG_PHASE_TICKS, 16'($urandom_range(1, 3)));
    write_reg(i2cbm_pkg::CFG_SETTLE_TICKS, 16'($urandom_range(1, 3)));
    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, 16'($urandom_range(1, 6)));
    random_ticks(90);
    calm <= 1'b0;

    write_reg(i2cbm_pkg::CFG_PHASE_TICKS, 16'd1);
    write_reg(i2cbm_pkg::CFG_SETTLE_TICKS, 16'd1);
    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, 16'd1);
    random_ticks(60);

    write_reg(i2cbm_pkg::CFG_PHASE_TICKS, 16'($urandom_range(2, 6)));
    write_reg(i2cbm_pkg::CFG_SETTLE_TICKS, 16'($urandom_range(1, 5)));
    write_reg(i2cbm_pkg::CFG_ACK_TIMEOUT, 16'($urandom_range(2, 20)));
    random_ticks(60);

    flush();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** i2c_bit_level_master: PASSED **");
    end else begin
      $display("** i2c_bit_level_master: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
